[rtl/fss_pkg.sv]
`default_nettype none

package fss_pkg;

   localparam int QUERY_DEPTH = 32;
   localparam int CHAR_BITS   = 16;
   localparam int ADDR_BITS   = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
   localparam int LEN_BITS    = $clog2(QUERY_DEPTH + 1);
   localparam int SCORE_BITS  = 9;
   localparam int GAIN_BITS   = 4;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

   localparam logic [GAIN_BITS-1:0] GAIN_MATCH    = GAIN_BITS'(1);
   localparam logic [GAIN_BITS-1:0] GAIN_ADJACENT = GAIN_BITS'(3);
   localparam logic [GAIN_BITS-1:0] GAIN_BOUNDARY = GAIN_BITS'(5);

   typedef logic [CHAR_BITS-1:0] char_type;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TARGET = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef struct packed {
      logic                  matched;
      logic [SCORE_BITS-1:0] score;
      logic                  query_overflow;
   } result_type;

   localparam char_type CH_0     = CHAR_BITS'('h30);
   localparam char_type CH_9     = CHAR_BITS'('h39);
   localparam char_type CH_UPPER_A = CHAR_BITS'('h41);
   localparam char_type CH_UPPER_Z = CHAR_BITS'('h5a);
   localparam char_type CH_LOWER_A = CHAR_BITS'('h61);
   localparam char_type CH_LOWER_Z = CHAR_BITS'('h7a);
   localparam char_type CASE_DELTA = CHAR_BITS'('h20);

   function automatic logic is_upper(char_type c);
      return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_lower(char_type c);
      return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
   endfunction

   function automatic logic is_alnum(char_type c);
      return ((c >= CH_0) && (c <= CH_9)) || is_upper(c) || is_lower(c);
   endfunction

   function automatic char_type fold_case(char_type c);
      return is_upper(c) ? char_type'(c + CASE_DELTA) : c;
   endfunction

endpackage

`default_nettype wire

[rtl/fuzzy_subsequence_scorer.sv]
`default_nettype none

// Greedy, case-insensitive subsequence scorer. Every beat is taken back to back,
// as long as results drain. The query lives in a RAM with one
// write and one registered read port; the read port is aimed at the entry after the current
// match position every cycle, so the query character needed after a hit is already waiting
// and a hit on every target character keeps full rate. An end-of-target beat's result is
// registered in the output register that drives the rsp_ port, or parked in one skid entry
// behind it while the rsp_ side stalls; the req_ side stalls only while two results wait on a stalled rsp_ side.
// An empty query reports a match with score 0; appends past the query depth are dropped and
// flagged until the next clear.
module fuzzy_subsequence_scorer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [15:0]                    req_character,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_matched,
   output logic [fss_pkg::SCORE_BITS-1:0]      rsp_score,
   output logic                                rsp_query_overflow
);

   localparam int AB = fss_pkg::ADDR_BITS;
   localparam int LB = fss_pkg::LEN_BITS;
   localparam int SB = fss_pkg::SCORE_BITS;
   localparam logic [LB-1:0] DEPTH_LEN = LB'(fss_pkg::QUERY_DEPTH);

   logic                 accept;
   fss_pkg::op_type      op;
   fss_pkg::char_type    ch;

   logic [LB-1:0]        len_ff, len_in;
   logic [LB-1:0]        mp_ff, mp_in;
   logic [SB-1:0]        score_ff, score_in;
   logic                 ovf_ff, ovf_in;
   logic                 prev_match_ff, prev_match_in;
   logic                 prev_alnum_ff, prev_alnum_in;
   logic                 prev_lower_ff, prev_lower_in;
   logic                 at_start_ff, at_start_in;
   fss_pkg::char_type    cur_ff, cur_in;
   fss_pkg::char_type    head_ff, head_in;

   logic                 wr_en;
   logic [LB-1:0]        rd_len;
   fss_pkg::char_type    ram_q;
   logic                 fwd_valid_ff, fwd_valid_in;
   fss_pkg::char_type    fwd_data_ff;
   fss_pkg::char_type    next_q;

   logic                 hit;
   logic                 boundary;
   logic [fss_pkg::GAIN_BITS-1:0] gain;
   logic [SB:0]          score_sum;

   logic                 new_rsp;
   fss_pkg::result_type  new_res;
   logic                 rsp_valid_ff, rsp_valid_in;
   fss_pkg::result_type  rsp_ff, rsp_in;
   logic                 skid_valid_ff, skid_valid_in;
   fss_pkg::result_type  skid_ff, skid_in;
   logic                 load_slot;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign op        = fss_pkg::op_type'(req_operation);
   assign ch        = req_character[fss_pkg::CHAR_BITS-1:0];

   // ---------------- query store ----------------
   assign wr_en  = accept && (op == fss_pkg::OP_APPEND) && (len_ff < DEPTH_LEN);
   assign rd_len = mp_in + LB'(1);

   fss_ram #(
      .WIDTH (fss_pkg::CHAR_BITS),
      .DEPTH (fss_pkg::QUERY_DEPTH)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[AB-1:0]),
      .wr_data (ch),
      .rd_addr (rd_len[AB-1:0]),
      .rd_data (ram_q)
   );

   // forward a write that lands on the entry being read
   assign fwd_valid_in = wr_en && (len_ff == rd_len);
   assign next_q       = fwd_valid_ff ? fwd_data_ff : ram_q;

   // ---------------- match and score ----------------
   always_comb begin
      hit      = (mp_ff < len_ff) && (fss_pkg::fold_case(ch) == fss_pkg::fold_case(cur_ff));
      boundary = at_start_ff || !prev_alnum_ff || (prev_lower_ff && fss_pkg::is_upper(ch));
      gain     = fss_pkg::GAIN_MATCH
               + (prev_match_ff ? fss_pkg::GAIN_ADJACENT : '0)
               + (boundary ? fss_pkg::GAIN_BOUNDARY : '0);
      score_sum = {1'b0, score_ff} + (SB + 1)'(gain);
   end

   always_comb begin
      len_in        = len_ff;
      mp_in         = mp_ff;
      score_in      = score_ff;
      ovf_in        = ovf_ff;
      prev_match_in = prev_match_ff;
      prev_alnum_in = prev_alnum_ff;
      prev_lower_in = prev_lower_ff;
      at_start_in   = at_start_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      new_rsp       = 1'b0;
      new_res.matched        = (mp_ff >= len_ff);
      new_res.score          = (mp_ff >= len_ff) ? score_ff : '0;
      new_res.query_overflow = ovf_ff;

      if (accept) begin
         case (op)
            fss_pkg::OP_CLEAR: begin
               len_in        = '0;
               ovf_in        = 1'b0;
               mp_in         = '0;
               score_in      = '0;
               prev_match_in = 1'b0;
               prev_alnum_in = 1'b0;
               prev_lower_in = 1'b0;
               at_start_in   = 1'b1;
            end
            fss_pkg::OP_APPEND: begin
               if (len_ff < DEPTH_LEN) begin
                  len_in = len_ff + LB'(1);
                  if (len_ff == mp_ff) begin
                     cur_in = ch;
                  end
                  if (len_ff == '0) begin
                     head_in = ch;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            fss_pkg::OP_TARGET: begin
               if (hit) begin
                  mp_in    = mp_ff + LB'(1);
                  cur_in   = next_q;
                  score_in = (score_sum > (SB + 1)'(fss_pkg::SCORE_MAX))
                           ? fss_pkg::SCORE_MAX : score_sum[SB-1:0];
               end
               prev_match_in = hit;
               prev_alnum_in = fss_pkg::is_alnum(ch);
               prev_lower_in = fss_pkg::is_lower(ch);
               at_start_in   = 1'b0;
            end
            fss_pkg::OP_END: begin
               new_rsp       = 1'b1;
               mp_in         = '0;
               cur_in        = head_ff;
               score_in      = '0;
               prev_match_in = 1'b0;
               prev_alnum_in = 1'b0;
               prev_lower_in = 1'b0;
               at_start_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- result register and skid ----------------
   assign load_slot = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (load_slot) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = new_rsp;
            skid_in       = new_res;
         end else begin
            rsp_valid_in  = new_rsp;
            rsp_in        = new_res;
         end
      end else if (new_rsp) begin
         // hold the waiting beat, park the new one
         skid_valid_in = 1'b1;
         skid_in       = new_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = rsp_ff.matched;
   assign rsp_score          = rsp_ff.score;
   assign rsp_query_overflow = rsp_ff.query_overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         mp_ff         <= '0;
         score_ff      <= '0;
         ovf_ff        <= 1'b0;
         prev_match_ff <= 1'b0;
         prev_alnum_ff <= 1'b0;
         prev_lower_ff <= 1'b0;
         at_start_ff   <= 1'b1;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         mp_ff         <= mp_in;
         score_ff      <= score_in;
         ovf_ff        <= ovf_in;
         prev_match_ff <= prev_match_in;
         prev_alnum_ff <= prev_alnum_in;
         prev_lower_ff <= prev_lower_in;
         at_start_ff   <= at_start_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      head_ff     <= head_in;
      fwd_data_ff <= ch;
      rsp_ff      <= rsp_in;
      skid_ff     <= skid_in;
   end

`ifndef SYNTHESIS
   a_mp_within_len: assert property (@(posedge clock) disable iff (reset)
      mp_ff <= len_ff)
      else $error("match position passed query length");

   a_len_within_depth: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_LEN)
      else $error("query length passed depth");

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty output register");

   a_unmatched_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.matched) |-> (rsp_ff.score == '0))
      else $error("unmatched result carries a score");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == fss_pkg::OP_END)) |=> (at_start_ff && (mp_ff == '0)))
      else $error("target state not restarted after end of target");
`endif

endmodule

`default_nettype wire

[rtl/fss_ram.sv]
`default_nettype none

module fss_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 32,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old entry on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
